FILE: sv/bbpc_pkg.sv
// Shared constants and types for the binary boundary pixel counter.
package bbpc_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_COUNT_BITS = 24;

   localparam int FRAME_BITS    = 13;
   localparam int ROW_BITS      = 12;
   localparam int OUT_BITS      = 24;
   localparam int CSR_ADDR_BITS = 1;
   localparam int REQ_BYTES     = 1;
   localparam int RSP_BITS      = 2 * OUT_BITS;

   localparam logic [FRAME_BITS-1:0] ROW_LIMIT         = 13'd4096;
   localparam logic [FRAME_BITS-1:0] WIDTH_RESET       = 13'd640;
   localparam logic [FRAME_BITS-1:0] HEIGHT_RESET      = 13'd480;

   localparam logic [CSR_ADDR_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

   // scan -> tally
   typedef struct packed {
      logic [1:0] boundary_inc;
      logic       white_inc;
      logic       done;
   } tally_req_type;

endpackage

FILE: sv/bbpc_scan.sv
// Pixel scan: line store, 3x3 window, boundary judging and end-of-frame pass.
module bbpc_scan #(
   parameter int MAX_WIDTH = bbpc_pkg::DEF_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic                               pixel_white,
   input  logic [bbpc_pkg::FRAME_BITS-1:0]    frame_width,
   input  logic [bbpc_pkg::FRAME_BITS-1:0]    frame_height,
   input  logic                               tally_ready,
   output bbpc_pkg::tally_req_type            tally_req
);
   import bbpc_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WCMP = (CW + 1 > FRAME_BITS) ? CW + 1 : FRAME_BITS;

   // win bit x*3+y: x 0 left, 1 center, 2 right; y 0 up, 1 mid, 2 down
   function automatic logic is_boundary(input logic [8:0] win, input logic up_ok,
                                        input logic dn_ok, input logic lt_ok,
                                        input logic rt_ok);
      logic [8:0] mask;
      for (int x = 0; x < 3; x++) begin
         for (int y = 0; y < 3; y++) begin
            mask[x*3+y] = (x != 0 || lt_ok) && (x != 2 || rt_ok) &&
                          (y != 0 || up_ok) && (y != 2 || dn_ok) &&
                          !(x == 1 && y == 1);
         end
      end
      return win[4] & (|(~win & mask));
   endfunction

   // line store: bit 1 previous row, bit 0 the row before it
   logic [1:0]    line_mem [MAX_WIDTH];
   logic [1:0]    line_q_ff;
   logic [CW-1:0] rd_addr;
   logic [1:0]    line_rd;
   logic          byp_ff, byp_in;
   logic [1:0]    byp_data_ff;

   logic [CW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                accept;
   logic [WCMP-1:0]     col_next;
   logic [FRAME_BITS-1:0] row_next;
   logic                row_end, frame_end;

   // stage B
   logic          b_valid_ff;
   logic          b_pix_ff;
   logic [CW-1:0] b_col_ff;
   logic          b_row_nz_ff, b_row_ge2_ff, b_col_nz_ff, b_col_ge2_ff;
   logic          b_row_end_ff, b_frame_end_ff;
   logic [8:0]    window_ff, window_in;
   logic [8:0]    win_next;
   logic          j_mid, j_end;
   logic          b_start;

   // final-row pass
   logic          fl_run_ff, fl_run_in;
   logic [CW-1:0] fl_addr_ff, fl_addr_in;
   logic [CW-1:0] fl_last_ff;
   logic          fl_rownz_ff;
   logic          fl_dv_ff;
   logic [CW-1:0] fl_da_ff;
   logic          fl_emit_ff, fl_emit_in;
   logic [8:0]    fl_win_ff, fl_win_in;
   logic [8:0]    fwin;
   logic          f_last, jf_mid, jf_end;

   assign in_ready = !(b_valid_ff && b_frame_end_ff) && !fl_run_ff && !fl_dv_ff
                     && !fl_emit_ff;
   assign accept   = in_valid && in_ready;

   assign col_next  = WCMP'(col_ff) + WCMP'(1);
   assign row_next  = FRAME_BITS'(row_ff) + FRAME_BITS'(1);
   assign row_end   = (col_next >= WCMP'(frame_width)) || (col_next >= WCMP'(MAX_WIDTH));
   assign frame_end = (row_next >= frame_height) || (row_next >= ROW_LIMIT);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_next[ROW_BITS-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   assign rd_addr = fl_run_ff ? fl_addr_ff : col_ff;
   assign byp_in  = accept && b_valid_ff && (b_col_ff == col_ff);
   assign line_rd = byp_ff ? byp_data_ff : line_q_ff;

   always_ff @(posedge clock) begin
      line_q_ff <= line_mem[rd_addr];
      if (b_valid_ff) begin
         line_mem[b_col_ff] <= {b_pix_ff, line_rd[1]};
      end
   end

   // stage B judging
   assign win_next = {b_pix_ff, line_rd[1], line_rd[0], window_ff[8:3]};
   assign j_mid = b_row_nz_ff && b_col_nz_ff &&
                  is_boundary(win_next, b_row_ge2_ff, 1'b1, b_col_ge2_ff, 1'b1);
   assign j_end = b_row_end_ff && b_row_nz_ff &&
                  is_boundary({3'b000, win_next[8:3]}, b_row_ge2_ff, 1'b1, b_col_nz_ff,
                              1'b0);
   assign b_start = b_valid_ff && b_frame_end_ff;

   always_comb begin
      window_in = window_ff;
      if (b_valid_ff) begin
         window_in = b_row_end_ff ? '0 : win_next;
      end
   end

   // final row: one column a cycle from the line store
   assign fwin   = {1'b0, line_rd[1], line_rd[0], fl_win_ff[8:3]};
   assign f_last = (fl_da_ff == fl_last_ff);
   assign jf_mid = fl_dv_ff && (fl_da_ff != '0) &&
                   is_boundary(fwin, fl_rownz_ff, 1'b0, fl_da_ff > CW'(1), 1'b1);
   assign jf_end = fl_dv_ff && f_last &&
                   is_boundary({3'b000, fwin[8:3]}, fl_rownz_ff, 1'b0, fl_da_ff != '0, 1'b0);

   always_comb begin
      fl_run_in  = fl_run_ff;
      fl_addr_in = fl_addr_ff;
      fl_win_in  = fl_win_ff;
      fl_emit_in = fl_emit_ff;
      if (b_start) begin
         fl_run_in  = 1'b1;
         fl_addr_in = '0;
         fl_win_in  = '0;
      end else if (fl_run_ff) begin
         if (fl_addr_ff == fl_last_ff) begin
            fl_run_in = 1'b0;
         end else begin
            fl_addr_in = fl_addr_ff + CW'(1);
         end
      end
      if (fl_dv_ff) begin
         fl_win_in = fwin;
         if (f_last) begin
            fl_emit_in = 1'b1;
         end
      end
      if (fl_emit_ff && tally_ready) begin
         fl_emit_in = 1'b0;
      end
   end

   always_comb begin
      tally_req.boundary_inc = b_valid_ff ? (2'(j_mid) + 2'(j_end))
                                          : (2'(jf_mid) + 2'(jf_end));
      tally_req.white_inc    = b_valid_ff && b_pix_ff;
      tally_req.done         = fl_emit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         b_valid_ff <= 1'b0;
         byp_ff     <= 1'b0;
         window_ff  <= '0;
         fl_run_ff  <= 1'b0;
         fl_dv_ff   <= 1'b0;
         fl_emit_ff <= 1'b0;
         fl_addr_ff <= '0;
         fl_win_ff  <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         b_valid_ff <= accept;
         byp_ff     <= byp_in;
         window_ff  <= window_in;
         fl_run_ff  <= fl_run_in;
         fl_dv_ff   <= fl_run_ff;
         fl_emit_ff <= fl_emit_in;
         fl_addr_ff <= fl_addr_in;
         fl_win_ff  <= fl_win_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= {b_pix_ff, line_rd[1]};
      fl_da_ff    <= fl_addr_ff;
      if (accept) begin
         b_pix_ff        <= pixel_white;
         b_col_ff        <= col_ff;
         b_row_nz_ff     <= (row_ff != '0);
         b_row_ge2_ff    <= (row_ff > ROW_BITS'(1));
         b_col_nz_ff     <= (col_ff != '0);
         b_col_ge2_ff    <= (col_ff > CW'(1));
         b_row_end_ff    <= row_end;
         b_frame_end_ff  <= row_end && frame_end;
      end
      if (b_start) begin
         fl_last_ff  <= b_col_ff;
         fl_rownz_ff <= b_row_nz_ff;
      end
   end

endmodule

FILE: sv/bbpc_tally.sv
// Saturating boundary and area totals with the result register.
module bbpc_tally #(
   parameter int COUNT_BITS = bbpc_pkg::DEF_COUNT_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bbpc_pkg::tally_req_type          tally_req,
   output logic                             tally_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bbpc_pkg::OUT_BITS-1:0]    boundary_count,
   output logic [bbpc_pkg::OUT_BITS-1:0]    white_count
);
   import bbpc_pkg::*;

   logic [COUNT_BITS-1:0] bnd_ff, bnd_in;
   logic [COUNT_BITS-1:0] wht_ff, wht_in;
   logic [COUNT_BITS:0]   bnd_sum, wht_sum;
   logic [COUNT_BITS-1:0] bnd_sat, wht_sat;
   logic [COUNT_BITS+OUT_BITS-1:0] bnd_ext, wht_ext;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]   bnd_out_ff, wht_out_ff;
   logic                  emit;

   assign tally_ready = !rsp_valid_ff || rsp_ready;
   assign emit        = tally_req.done && tally_ready;

   assign bnd_sum = {1'b0, bnd_ff} + (COUNT_BITS+1)'(tally_req.boundary_inc);
   assign wht_sum = {1'b0, wht_ff} + (COUNT_BITS+1)'(tally_req.white_inc);
   assign bnd_sat = bnd_sum[COUNT_BITS] ? '1 : bnd_sum[COUNT_BITS-1:0];
   assign wht_sat = wht_sum[COUNT_BITS] ? '1 : wht_sum[COUNT_BITS-1:0];
   assign bnd_ext = {{OUT_BITS{1'b0}}, bnd_sat};
   assign wht_ext = {{OUT_BITS{1'b0}}, wht_sat};

   always_comb begin
      bnd_in       = bnd_sat;
      wht_in       = wht_sat;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         bnd_in       = '0;
         wht_in       = '0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_ff       <= '0;
         wht_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bnd_ff       <= bnd_in;
         wht_ff       <= wht_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         bnd_out_ff <= bnd_ext[OUT_BITS-1:0];
         wht_out_ff <= wht_ext[OUT_BITS-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign boundary_count = bnd_out_ff;
   assign white_count    = wht_out_ff;

endmodule

FILE: sv/binary_boundary_pixel_counter.sv
// Top level of the binary boundary pixel counter.
//
// Takes one binary pixel per request in raster order and, after the last pixel of
// each frame, returns one result: the count of white pixels that have a black
// neighbor inside the image (8-connected) and the count of all white pixels,
// both saturating. Frame width and height come from the two configuration
// registers. Within a frame a pixel is accepted every clock. After the last
// pixel of a frame req_tready stays low while the final row is read back from
// the line store one column per cycle and judged, and until the result enters
// the result register, which waits while the previous result has not been
// taken. The row width is frame_width held to 1..MAX_WIDTH.
module binary_boundary_pixel_counter #(
   parameter int MAX_WIDTH  = bbpc_pkg::DEF_MAX_WIDTH,
   parameter int COUNT_BITS = bbpc_pkg::DEF_COUNT_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [8*bbpc_pkg::REQ_BYTES-1:0]       req_tdata,   // [0] pixel_white
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [bbpc_pkg::RSP_BITS-1:0]          rsp_tdata,   // [23:0] boundary_count,
                                                               // [47:24] white_count
   input  logic                                   csr_we,
   input  logic [bbpc_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [bbpc_pkg::FRAME_BITS-1:0]        csr_wdata
);
   import bbpc_pkg::*;

   logic [FRAME_BITS-1:0] width_ff, width_in;
   logic [FRAME_BITS-1:0] height_ff, height_in;
   tally_req_type         tally_req;
   logic                  tally_ready;
   logic [OUT_BITS-1:0]   boundary_count, white_count;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_FRAME_WIDTH: begin
               width_in = csr_wdata;
            end
            REG_FRAME_HEIGHT: begin
               height_in = csr_wdata;
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   bbpc_scan #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .pixel_white  (req_tdata[0]),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .tally_ready  (tally_ready),
      .tally_req    (tally_req)
   );

   bbpc_tally #(
      .COUNT_BITS (COUNT_BITS)
   ) u_tally (
      .clock          (clock),
      .reset          (reset),
      .tally_req      (tally_req),
      .tally_ready    (tally_ready),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .boundary_count (boundary_count),
      .white_count    (white_count)
   );

   assign rsp_tdata = {white_count, boundary_count};

endmodule
